// ===== hw/rtl/atq_pkg.sv =====
// Shared widths, constants, item type and clamp helper for the tilt quaternion unit.
// No dependencies; every other file refers to this package by scoped names.
package atq_pkg;

  localparam int QW          = 16;  // field width, signed Q1.14
  localparam int MW          = 15;  // magnitude of a clamped component
  localparam int TW          = 16;  // t = 1 +/- az, in [16384, 32768]
  localparam int LW          = 15;  // lambda, up to 16384
  localparam int RADW        = 30;  // square root radicand, 15 bit pairs
  localparam int SQ_STEPS    = 15;  // one root bit per stage
  localparam int SRW         = 19;  // square root partial remainder
  localparam int QTW         = 14;  // quotient bits
  localparam int DW          = 16;  // divisor 2*lambda
  localparam int DRW         = 30;  // divider partial remainder
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [QW-1:0] Q_ONE     = 16'sd16384;
  localparam logic signed [QW-1:0] Q_NEG_ONE = -16'sd16384;
  localparam logic [QTW:0]         Q_MAG_MAX = 15'd16384;

  typedef struct packed {
    logic [MW-1:0] mag_a;  // |ay|
    logic [MW-1:0] mag_b;  // |ax|
    logic          neg_a;  // sign of the ay quotient
    logic          neg_b;  // sign of the -ax quotient
    logic          upper;  // az >= 0
    logic [TW-1:0] t;
  } atq_item_t;

  function automatic logic signed [QW-1:0] clamp_q(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] r;
    r = v;
    if (v > Q_ONE) r = Q_ONE;
    if (v < Q_NEG_ONE) r = Q_NEG_ONE;
    return r;
  endfunction

endpackage

// ===== hw/rtl/atq_if.sv =====
// Valid/ready channel interfaces for accelerometer samples and quaternions.
// Depends on atq_pkg for the field width.
interface accel_if;
  logic                            valid;
  logic                            ready;
  logic signed [atq_pkg::QW-1:0]   accel_x;
  logic signed [atq_pkg::QW-1:0]   accel_y;
  logic signed [atq_pkg::QW-1:0]   accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface quat_if;
  logic                            valid;
  logic                            ready;
  logic signed [atq_pkg::QW-1:0]   quat_w;
  logic signed [atq_pkg::QW-1:0]   quat_x;
  logic signed [atq_pkg::QW-1:0]   quat_y;
  logic signed [atq_pkg::QW-1:0]   quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== hw/rtl/atq_front.sv =====
// Front end: accepts a sample, clamps it, picks the hemisphere and registers the item.
// Depends on atq_pkg and accel_if.
module atq_front (
  input  logic                clk,
  input  logic                rst,
  accel_if.sink               acc,
  output logic                push_valid,
  input  logic                push_ready,
  output atq_pkg::atq_item_t  push_item
);

  logic                          fv;
  logic signed [atq_pkg::QW-1:0] ax, ay, az;
  logic signed [atq_pkg::QW-1:0] abs_x, abs_y;
  logic signed [atq_pkg::QW:0]   t_wide;
  atq_pkg::atq_item_t            item_next;

  assign acc.ready  = !fv || push_ready;
  assign push_valid = fv;

  always_comb begin
    ax     = atq_pkg::clamp_q(acc.accel_x);
    ay     = atq_pkg::clamp_q(acc.accel_y);
    az     = atq_pkg::clamp_q(acc.accel_z);
    abs_x  = ax[atq_pkg::QW-1] ? -ax : ax;
    abs_y  = ay[atq_pkg::QW-1] ? -ay : ay;
    item_next.upper = !az[atq_pkg::QW-1];
    if (item_next.upper) begin
      t_wide = 17'(az) + 17'(atq_pkg::Q_ONE);
    end else begin
      t_wide = 17'(atq_pkg::Q_ONE) - 17'(az);
    end
    item_next.t     = t_wide[atq_pkg::TW-1:0];
    item_next.mag_a = abs_y[atq_pkg::MW-1:0];
    item_next.mag_b = abs_x[atq_pkg::MW-1:0];
    // x = ay/(2l) on the upper branch, w = -ay/(2l) on the lower one
    item_next.neg_a = item_next.upper ? (ay < 0) : (ay > 0);
    item_next.neg_b = ax > 0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (acc.ready) begin
      fv <= acc.valid;
    end
    if (acc.ready && acc.valid) begin
      push_item <= item_next;
    end
  end

endmodule

// ===== hw/rtl/atq_queue.sv =====
// Small register FIFO decoupling the front end from the arithmetic back end.
// Depends on atq_pkg for the item type.
module atq_queue #(
  parameter int DEPTH = atq_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  atq_pkg::atq_item_t  push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output atq_pkg::atq_item_t  pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  atq_pkg::atq_item_t mem [DEPTH];
  logic [AW-1:0]      wptr, rptr;
  logic [CW-1:0]      count;
  logic               push, pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/atq_back.sv =====
// Back end: pipelined square root, two pipelined dividers and the output register.
// Depends on atq_pkg and quat_if.
module atq_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  atq_pkg::atq_item_t  pop_item,
  quat_if.source              quat
);

  localparam int NS = atq_pkg::SQ_STEPS;
  localparam int ND = atq_pkg::QTW;

  typedef struct packed {
    logic [atq_pkg::MW-1:0]   mag_a;
    logic [atq_pkg::MW-1:0]   mag_b;
    logic                     neg_a;
    logic                     neg_b;
    logic                     upper;
    logic [atq_pkg::RADW-1:0] rad;
    logic [atq_pkg::LW-1:0]   root;
    logic [atq_pkg::SRW-1:0]  rem;
  } sq_t;

  typedef struct packed {
    logic                     neg_a;
    logic                     neg_b;
    logic                     upper;
    logic [atq_pkg::LW-1:0]   lambda;
    logic [atq_pkg::DW-1:0]   d;
    logic [atq_pkg::DRW-1:0]  ra;
    logic [atq_pkg::DRW-1:0]  rb;
    logic [ND-1:0]            qa;
    logic [ND-1:0]            qb;
  } dv_t;

  logic        adv;
  sq_t         sq  [NS+1];
  logic        sqv [NS+1];
  dv_t         dv  [ND+1];
  logic        dvv [ND+1];

  logic [atq_pkg::LW-1:0]  lam_r;
  logic [atq_pkg::QTW:0]   qa_s, qb_s;
  logic signed [atq_pkg::QW-1:0] lam_s, va, vb;

  // whole pipeline moves together whenever the output slot can take a result
  assign adv       = !quat.valid || quat.ready;
  assign pop_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else if (adv) begin
      sqv[0] <= pop_valid;
    end
    if (adv) begin
      sq[0].mag_a <= pop_item.mag_a;
      sq[0].mag_b <= pop_item.mag_b;
      sq[0].neg_a <= pop_item.neg_a;
      sq[0].neg_b <= pop_item.neg_b;
      sq[0].upper <= pop_item.upper;
      sq[0].rad   <= {1'b0, pop_item.t, 13'd0};  // t * 8192
      sq[0].root  <= '0;
      sq[0].rem   <= '0;
    end
  end

  for (genvar i = 1; i <= NS; i++) begin : g_sqrt
    logic [atq_pkg::SRW-1:0] cur, trial;
    sq_t                     nxt;
    always_comb begin
      nxt   = sq[i-1];
      cur   = {sq[i-1].rem[atq_pkg::SRW-3:0], sq[i-1].rad[atq_pkg::RADW-1 -: 2]};
      trial = atq_pkg::SRW'({sq[i-1].root, 2'b01});
      nxt.rad = {sq[i-1].rad[atq_pkg::RADW-3:0], 2'b00};
      if (cur >= trial) begin
        nxt.rem  = cur - trial;
        nxt.root = {sq[i-1].root[atq_pkg::LW-2:0], 1'b1};
      end else begin
        nxt.rem  = cur;
        nxt.root = {sq[i-1].root[atq_pkg::LW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[i] <= 1'b0;
      end else if (adv) begin
        sqv[i] <= sqv[i-1];
      end
      if (adv) begin
        sq[i] <= nxt;
      end
    end
  end

  // round the root to nearest: up when remainder exceeds the root
  always_comb begin
    lam_r = sq[NS].root + atq_pkg::LW'(atq_pkg::SRW'(sq[NS].root) < sq[NS].rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= sqv[NS];
    end
    if (adv) begin
      dv[0].neg_a  <= sq[NS].neg_a;
      dv[0].neg_b  <= sq[NS].neg_b;
      dv[0].upper  <= sq[NS].upper;
      dv[0].lambda <= lam_r;
      dv[0].d      <= {lam_r, 1'b0};
      dv[0].ra     <= atq_pkg::DRW'({sq[NS].mag_a, 14'd0}) + atq_pkg::DRW'(lam_r);
      dv[0].rb     <= atq_pkg::DRW'({sq[NS].mag_b, 14'd0}) + atq_pkg::DRW'(lam_r);
      dv[0].qa     <= '0;
      dv[0].qb     <= '0;
    end
  end

  for (genvar i = 1; i <= ND; i++) begin : g_div
    localparam int SH = ND - i;
    logic [atq_pkg::DRW-1:0] ds;
    dv_t                     nxt;
    always_comb begin
      nxt = dv[i-1];
      ds  = atq_pkg::DRW'(dv[i-1].d) << SH;
      if (dv[i-1].ra >= ds) begin
        nxt.ra = dv[i-1].ra - ds;
        nxt.qa = {dv[i-1].qa[ND-2:0], 1'b1};
      end else begin
        nxt.qa = {dv[i-1].qa[ND-2:0], 1'b0};
      end
      if (dv[i-1].rb >= ds) begin
        nxt.rb = dv[i-1].rb - ds;
        nxt.qb = {dv[i-1].qb[ND-2:0], 1'b1};
      end else begin
        nxt.qb = {dv[i-1].qb[ND-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[i] <= 1'b0;
      end else if (adv) begin
        dvv[i] <= dvv[i-1];
      end
      if (adv) begin
        dv[i] <= nxt;
      end
    end
  end

  always_comb begin
    qa_s  = (atq_pkg::QTW+1)'(dv[ND].qa);
    qb_s  = (atq_pkg::QTW+1)'(dv[ND].qb);
    if (qa_s > atq_pkg::Q_MAG_MAX) qa_s = atq_pkg::Q_MAG_MAX;
    if (qb_s > atq_pkg::Q_MAG_MAX) qb_s = atq_pkg::Q_MAG_MAX;
    va    = dv[ND].neg_a ? -$signed({1'b0, qa_s}) : $signed({1'b0, qa_s});
    vb    = dv[ND].neg_b ? -$signed({1'b0, qb_s}) : $signed({1'b0, qb_s});
    lam_s = $signed({1'b0, dv[ND].lambda});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
    end else if (adv) begin
      quat.valid <= dvv[ND];
    end
    if (adv) begin
      if (dv[ND].upper) begin
        quat.quat_w <= lam_s;
        quat.quat_x <= va;
        quat.quat_y <= vb;
        quat.quat_z <= '0;
      end else begin
        quat.quat_w <= va;
        quat.quat_x <= -lam_s;
        quat.quat_y <= '0;
        quat.quat_z <= vb;
      end
    end
  end

endmodule

// ===== hw/rtl/accel_tilt_quaternion_unit.sv =====
// Tilt quaternion from a normalised accelerometer vector, top level.
// Depends on atq_pkg, atq_if, atq_front, atq_queue and atq_back.
//
// One sample (accel_x, accel_y, accel_z, signed Q1.14, clamped to +/-1) gives one
// quaternion (w, x, y, z) in signed Q1.14. For az >= 0: w = lambda, x = ay/(2 lambda),
// y = -ax/(2 lambda), z = 0 with lambda = sqrt((1+az)/2); otherwise w = -ay/(2 lambda),
// x = -lambda, y = 0, z = -ax/(2 lambda) with lambda = sqrt((1-az)/2). Lambda is
// rounded to nearest, quotients to nearest with ties away from zero, outputs
// saturate to +/-1. The unit is fully pipelined and takes one sample every cycle
// unless the sink stalls and the queue fills. The front register loads at the input
// transfer, then the item is written to the queue and passes the square root stages
// (operand load plus 15 stages at one root bit each), the divider stages
// (rounded root and dividend load plus 14 stages at one quotient bit each) and the
// output register. Latency grows only while the sink stalls. The front end keeps
// accepting into a QUEUE_DEPTH entry FIFO while the back end is held.
module accel_tilt_quaternion_unit #(
  parameter int QUEUE_DEPTH = atq_pkg::QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  accel_if.sink   acc,
  quat_if.source  quat
);

  logic               push_valid, push_ready;
  logic               pop_valid, pop_ready;
  atq_pkg::atq_item_t push_item, pop_item;

  // classify and register the incoming sample
  atq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue between front and back
  atq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // square root, dividers and result register
  atq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .quat      (quat)
  );

  // one hemisphere only: y or z is always zero
  a_one_zero: assert property (@(posedge clk) disable iff (rst)
    quat.valid |-> (quat.quat_y == '0 || quat.quat_z == '0))
    else $error("both y and z non-zero");

  // scalar part stays within +/-1
  a_w_range: assert property (@(posedge clk) disable iff (rst)
    quat.valid |-> (quat.quat_w <= atq_pkg::Q_ONE && quat.quat_w >= atq_pkg::Q_NEG_ONE))
    else $error("quat_w out of range");

  // a registered item not taken by the queue is still offered next cycle
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (push_valid && !push_ready) |=> push_valid)
    else $error("front item dropped");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !quat.valid)
    else $error("result valid after reset");

endmodule

// ===== dv/atq_tb_pkg.sv =====
// Testbench types for the tilt quaternion unit: expected quaternion record.
// Depends on atq_pkg for the field width.
package atq_tb_pkg;

  typedef struct {
    logic signed [atq_pkg::QW-1:0] w;
    logic signed [atq_pkg::QW-1:0] x;
    logic signed [atq_pkg::QW-1:0] y;
    logic signed [atq_pkg::QW-1:0] z;
  } quat_t;

endpackage

// ===== dv/tb_top.sv =====
// Testbench for accel_tilt_quaternion_unit: directed and random samples, predicted
// quaternions checked in order against the result channel under random idling.
// Depends on atq_pkg, atq_tb_pkg and the RTL interfaces accel_if and quat_if.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  accel_if acc ();
  quat_if  quat ();

  accel_tilt_quaternion_unit i_dut (
    .clk  (clk),
    .rst  (rst),
    .acc  (acc.sink),
    .quat (quat.source)
  );

  atq_tb_pkg::quat_t expected_quats[$];
  int    n_mismatch = 0;
  int    n_checked  = 0;
  int    n_upper    = 0;
  int    n_lower    = 0;
  int    send_idle  = 0;  // percent chance the sender inserts a gap
  int    recv_stall = 0;  // percent chance the receiver holds ready low

  // Clamp a raw field to +/-1.0 in Q1.14
  function automatic int clamp_one(input logic signed [15:0] v);
    int r;
    r = v;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  // Rounded integer square root by bisection
  function automatic longint round_root(input longint n);
    longint s;
    s = 0;
    for (longint b = 64'd1 << 16; b > 0; b = b >> 1)
      if ((s + b) * (s + b) <= n) s = s + b;
    if (n - s * s > s) s = s + 1;
    return s;
  endfunction

  // n / (2 lambda) in Q1.14, nearest, ties away from zero, saturated
  function automatic int half_quot(input int n, input longint lam);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (m * 16384 + lam) / (2 * lam);
    if (q > 16384) q = 16384;
    return (n < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic atq_tb_pkg::quat_t tilt_quat(input logic signed [15:0] rx, ry, rz);
    atq_tb_pkg::quat_t q;
    int ax, ay, az;
    longint lam;
    ax = clamp_one(rx);
    ay = clamp_one(ry);
    az = clamp_one(rz);
    if (az >= 0) begin
      lam = round_root(longint'(az + 16384) * 8192);
      q.w = 16'(lam);
      q.x = 16'(half_quot(ay, lam));
      q.y = 16'(half_quot(-ax, lam));
      q.z = '0;
    end else begin
      lam = round_root(longint'(16384 - az) * 8192);
      q.w = 16'(half_quot(-ay, lam));
      q.x = 16'(-lam);
      q.y = '0;
      q.z = 16'(half_quot(-ax, lam));
    end
    return q;
  endfunction

  // Drive one sample and wait for its transfer; valid drops only during a gap
  task automatic send_sample(input logic signed [15:0] x, y, z);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      acc.valid <= 1'b0;
      @(negedge clk);
    end
    acc.valid   <= 1'b1;
    acc.accel_x <= x;
    acc.accel_y <= y;
    acc.accel_z <= z;
    @(posedge clk);
    while (!acc.ready) @(posedge clk);
    expected_quats.push_back(tilt_quat(x, y, z));
    if (z >= 0) n_upper++; else n_lower++;
    @(negedge clk);
  endtask

  // Receiver stall pattern, changed at the falling edge
  always @(negedge clk)
    quat.ready <= rst ? 1'b0 : !($urandom_range(99) < recv_stall);

  // Result checker, sampled at the rising edge
  always @(posedge clk) begin
    atq_tb_pkg::quat_t e;
    if (!rst && quat.valid && quat.ready) begin
      n_checked++;
      if (expected_quats.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected quaternion w=%0d x=%0d y=%0d z=%0d",
                                       quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
      end else begin
        e = expected_quats.pop_front();
        if (quat.quat_w !== e.w || quat.quat_x !== e.x ||
            quat.quat_y !== e.y || quat.quat_z !== e.z) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     e.w, e.x, e.y, e.z, quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // Corners: extremes, zeros, both az branches, out-of-range clamping
  task automatic test_directed();
    send_sample(16'sd0, 16'sd0, 16'sd16384);
    send_sample(16'sd0, 16'sd0, -16'sd16384);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, -16'sd1);
    send_sample(16'sd16384, 16'sd0, 16'sd0);
    send_sample(-16'sd16384, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd16384, -16'sd1);
    send_sample(16'sd0, -16'sd16384, -16'sd1);
    send_sample(16'sd16384, 16'sd16384, 16'sd16384);
    send_sample(-16'sd16384, -16'sd16384, -16'sd16384);
    send_sample(16'sd11585, -16'sd11585, 16'sd0);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h8000, 16'hffff);
    send_sample(16'sd16385, -16'sd16385, -16'sd16385);
    send_sample(16'hffff, 16'h0001, 16'sd1);
    send_sample(16'h5555, 16'haaaa, 16'h5555);
    send_sample(16'haaaa, 16'h5555, 16'haaaa);
  endtask

  // Random samples; in-range fields dominate, raw words exercise clamping
  task automatic test_random(input int n, input int idle, input int stall);
    send_idle  = idle;
    recv_stall = stall;
    repeat (n) send_sample(rand_field(), rand_field(), rand_field());
  endtask

  // Sender holds off until the pipeline has drained, then resumes
  task automatic test_drain_pause();
    test_random(20, 0, 50);
    acc.valid <= 1'b0;
    do @(negedge clk); while (expected_quats.size() != 0);
    test_random(20, 0, 0);
  endtask

  initial begin
    acc.valid   = 1'b0;
    acc.accel_x = '0;
    acc.accel_y = '0;
    acc.accel_z = '0;
    quat.ready  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(250, 0, 0);
    test_random(250, 72, 0);
    test_random(250, 0, 72);
    test_random(250, 35, 35);
    test_drain_pause();
    recv_stall = 0;
    acc.valid <= 1'b0;
    while (expected_quats.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    $display("Checked %0d quaternions from %0d upper and %0d lower hemisphere samples",
             n_checked, n_upper, n_lower);
    $display("with sender gaps, receiver stalls and a drain pause; %0d mismatches",
             n_mismatch);
    if (n_mismatch == 0 && expected_quats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
